@@ hw/rtl/fpb_pkg.sv @@
package fpb_pkg;

    // Parser phases; the two emit phases walk the payload memory
    typedef enum logic [2:0] {
        PH_HDR1    = 3'd0,
        PH_HDR2    = 3'd1,
        PH_LEN     = 3'd2,
        PH_CMD     = 3'd3,
        PH_DATA    = 3'd4,
        PH_CHK     = 3'd5,
        PH_EMIT_RD = 3'd6,
        PH_EMIT_WR = 3'd7
    } phase_t;

    // Register indexes on the configuration port
    localparam logic [7:0] CFG_SYNC_FIRST  = 8'd0;
    localparam logic [7:0] CFG_SYNC_SECOND = 8'd1;

    // Header bytes after reset
    localparam logic [7:0] SYNC_FIRST_RST  = 8'h55;
    localparam logic [7:0] SYNC_SECOND_RST = 8'hAA;

    localparam int CFG_IDX_W = 8;
    localparam int M_TDATA_W = 32;

endpackage

@@ hw/rtl/framed_packet_byte_parser_core.sv @@
// Channel   Direction  Payload
// s_        in         tdata[7:0] = rx_byte
// m_        out        tdata = frame_command, data_count, byte_position, data_value;
//                      tuser = data_present; tlast = last_of_frame
// cfg_      in         cfg_index = register index, cfg_data = register value
//
// One received byte is taken per cycle while parsing; the checksum byte waits
// until the output register is free.
// A good frame with N data bytes is then read out of the payload memory, each
// byte with one read step (EMIT_RD) and one load step (EMIT_WR); input is held
// off meanwhile. A frame without data gives its single result at once.
// aresetn is synchronous and active low; it clears the phase and the output valid and reloads the header bytes.
// A stalled m_ side holds the result and, while emitting, the memory walk.
module framed_packet_byte_parser_core #(
    parameter int MAX_DATA_BYTES = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // rx_byte
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,
    // frame_command[7:0], data_count[13:8], byte_position[18:14],
    // data_value[26:19], zero fill[31:27]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [fpb_pkg::M_TDATA_W-1:0]  m_tdata,
    // data_present[0]
    output logic                           m_tuser,
    output logic                           m_tlast,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [fpb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [7:0]                     cfg_data
);

    localparam int IDX_W = (MAX_DATA_BYTES > 1) ? $clog2(MAX_DATA_BYTES) : 1;
    localparam logic [7:0] LEN_MAX = 8'(MAX_DATA_BYTES + 1);
    localparam logic [6:0] STORE_DEPTH = 7'(MAX_DATA_BYTES);

    fpb_pkg::phase_t phase_reg, phase_next;

    logic [7:0] sync_first_reg, sync_second_reg;
    logic [7:0] frame_length_reg, frame_length_next;
    logic [7:0] held_command_reg, held_command_next;
    logic [7:0] running_check_reg, running_check_next;
    logic [5:0] data_received_reg, data_received_next;
    logic [5:0] emit_idx_reg, emit_idx_next;

    logic [7:0] payload_mem [MAX_DATA_BYTES];
    logic [7:0] rd_data_reg;

    logic       out_valid_reg;
    logic [7:0] out_cmd_reg;
    logic [5:0] out_count_reg;
    logic [4:0] out_pos_reg;
    logic [7:0] out_value_reg;
    logic       out_present_reg;
    logic       out_last_reg;

    logic       in_acc;
    logic       out_free;
    logic [7:0] rx_byte;
    logic [7:0] count8;
    logic       chk_match;
    logic       emit_last;
    logic       load_single;
    logic       load_emit;
    logic       mem_we;
    logic [5:0] dr_inc;

    assign rx_byte   = s_tdata;
    assign in_acc    = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign count8    = frame_length_reg - 8'd1;
    assign chk_match = (rx_byte == running_check_reg);
    assign emit_last = ((8'(emit_idx_reg) + 8'd1) == count8);
    assign dr_inc    = data_received_reg + 6'd1;

    assign load_single = in_acc && (phase_reg == fpb_pkg::PH_CHK) && chk_match &&
                         (count8 == 8'd0);
    assign load_emit   = (phase_reg == fpb_pkg::PH_EMIT_WR) && out_free;
    assign mem_we      = in_acc && (phase_reg == fpb_pkg::PH_DATA) &&
                         ({1'b0, data_received_reg} < STORE_DEPTH);

    // Next phase
    always_comb begin
        phase_next = phase_reg;
        case (phase_reg)
            fpb_pkg::PH_HDR1: begin
                if (in_acc && rx_byte == sync_first_reg) phase_next = fpb_pkg::PH_HDR2;
            end
            fpb_pkg::PH_HDR2: begin
                if (in_acc) begin
                    if (rx_byte == sync_second_reg)     phase_next = fpb_pkg::PH_LEN;
                    else if (rx_byte == sync_first_reg) phase_next = fpb_pkg::PH_HDR2;
                    else                                phase_next = fpb_pkg::PH_HDR1;
                end
            end
            fpb_pkg::PH_LEN: begin
                if (in_acc) begin
                    if (rx_byte == 8'd0 || rx_byte > LEN_MAX) phase_next = fpb_pkg::PH_HDR1;
                    else                                      phase_next = fpb_pkg::PH_CMD;
                end
            end
            fpb_pkg::PH_CMD: begin
                if (in_acc) begin
                    if (frame_length_reg > 8'd1) phase_next = fpb_pkg::PH_DATA;
                    else                         phase_next = fpb_pkg::PH_CHK;
                end
            end
            fpb_pkg::PH_DATA: begin
                if (in_acc && ({2'b00, dr_inc} >= count8)) phase_next = fpb_pkg::PH_CHK;
            end
            fpb_pkg::PH_CHK: begin
                if (in_acc) begin
                    if (chk_match && count8 != 8'd0) phase_next = fpb_pkg::PH_EMIT_RD;
                    else                             phase_next = fpb_pkg::PH_HDR1;
                end
            end
            fpb_pkg::PH_EMIT_RD: begin
                phase_next = fpb_pkg::PH_EMIT_WR;
            end
            fpb_pkg::PH_EMIT_WR: begin
                if (out_free) begin
                    if (emit_last) phase_next = fpb_pkg::PH_HDR1;
                    else           phase_next = fpb_pkg::PH_EMIT_RD;
                end
            end
            default: begin
                phase_next = fpb_pkg::PH_HDR1;
            end
        endcase
    end

    // Handshake outputs per phase
    always_comb begin
        case (phase_reg)
            fpb_pkg::PH_CHK:     s_tready = out_free;
            fpb_pkg::PH_EMIT_RD: s_tready = 1'b0;
            fpb_pkg::PH_EMIT_WR: s_tready = 1'b0;
            default:             s_tready = 1'b1;
        endcase
    end

    // Frame fields and checksum
    always_comb begin
        frame_length_next  = frame_length_reg;
        held_command_next  = held_command_reg;
        running_check_next = running_check_reg;
        data_received_next = data_received_reg;
        emit_idx_next      = emit_idx_reg;
        if (in_acc) begin
            case (phase_reg)
                fpb_pkg::PH_LEN: begin
                    frame_length_next  = rx_byte;
                    running_check_next = rx_byte;
                end
                fpb_pkg::PH_CMD: begin
                    held_command_next  = rx_byte;
                    running_check_next = running_check_reg ^ rx_byte;
                    data_received_next = 6'd0;
                end
                fpb_pkg::PH_DATA: begin
                    data_received_next = dr_inc;
                    running_check_next = running_check_reg ^ rx_byte;
                end
                fpb_pkg::PH_CHK: begin
                    emit_idx_next = 6'd0;
                end
                default: begin
                end
            endcase
        end
        if (load_emit) emit_idx_next = emit_idx_reg + 6'd1;
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= fpb_pkg::PH_HDR1;
            sync_first_reg  <= fpb_pkg::SYNC_FIRST_RST;
            sync_second_reg <= fpb_pkg::SYNC_SECOND_RST;
            out_valid_reg   <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == fpb_pkg::CFG_SYNC_FIRST)  sync_first_reg  <= cfg_data;
                if (cfg_index == fpb_pkg::CFG_SYNC_SECOND) sync_second_reg <= cfg_data;
            end
            if (out_free) out_valid_reg <= load_single || load_emit;
        end
    end

    // Frame registers
    always_ff @(posedge aclk) begin
        frame_length_reg  <= frame_length_next;
        held_command_reg  <= held_command_next;
        running_check_reg <= running_check_next;
        data_received_reg <= data_received_next;
        emit_idx_reg      <= emit_idx_next;
    end

    // Payload memory: write on data bytes, registered read at the emit index
    always_ff @(posedge aclk) begin
        if (mem_we) payload_mem[data_received_reg[IDX_W-1:0]] <= rx_byte;
        rd_data_reg <= payload_mem[emit_idx_reg[IDX_W-1:0]];
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (load_single) begin
            out_cmd_reg     <= held_command_reg;
            out_count_reg   <= 6'd0;
            out_pos_reg     <= 5'd0;
            out_value_reg   <= 8'd0;
            out_present_reg <= 1'b0;
            out_last_reg    <= 1'b1;
        end else if (load_emit) begin
            out_cmd_reg     <= held_command_reg;
            out_count_reg   <= count8[5:0];
            out_pos_reg     <= emit_idx_reg[4:0];
            out_value_reg   <= rd_data_reg;
            out_present_reg <= 1'b1;
            out_last_reg    <= emit_last;
        end
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {5'd0, out_value_reg, out_pos_reg, out_count_reg, out_cmd_reg};
    assign m_tuser   = out_present_reg;
    assign m_tlast   = out_last_reg;

    // Input is held off during the memory walk
    a_no_input_in_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == fpb_pkg::PH_EMIT_RD || phase_reg == fpb_pkg::PH_EMIT_WR) |-> !s_tready)
        else $error("input accepted while emitting a frame");

    // A result without data is always the sole, last result of its frame
    a_empty_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tlast && out_count_reg == 6'd0))
        else $error("empty result is not the last of its frame");

    // Data capture starts at store index zero
    a_data_starts_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(phase_reg) == fpb_pkg::PH_CMD && phase_reg == fpb_pkg::PH_DATA)
        |-> data_received_reg == 6'd0)
        else $error("data capture did not start at index zero");

endmodule

@@ test/framed_packet_byte_parser_core_test.sv @@
module framed_packet_byte_parser_core_test;

    localparam int PAYLOAD_MAX  = 32;
    localparam int SETTLE_TICKS = 16;
    localparam int STALL_AT     = 150;
    localparam int STALL_TICKS  = 300;
    localparam int BUDGET       = 75;

    // One result beat of an accepted frame
    typedef struct packed {
        logic [7:0] frame_command;
        logic [5:0] data_count;
        logic [4:0] byte_position;
        logic [7:0] data_value;
        logic       data_present;
        logic       last_of_frame;
    } frame_beat_t;

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [7:0]                     s_tdata   = '0;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [fpb_pkg::M_TDATA_W-1:0]  m_tdata;
    logic                           m_tuser;
    logic                           m_tlast;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [fpb_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [7:0]                     cfg_data  = '0;

    framed_packet_byte_parser_core #(
        .MAX_DATA_BYTES(PAYLOAD_MAX)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Bytes waiting to be sent and beats waiting to be received
    logic [7:0]  rx_bytes_pending[$];
    frame_beat_t frame_beats_due[$];
    int unsigned bytes_queued = 0;
    int unsigned bytes_in     = 0;
    int unsigned mismatches   = 0;
    bit          quiet        = 1'b0;
    int          in_gap       = 0;
    int          out_gap      = 0;
    int          stall_left   = 0;
    bit          stall_done   = 1'b0;

    // Parser mirror: header bytes and frame state
    logic [7:0]      hdr_first  = fpb_pkg::SYNC_FIRST_RST;
    logic [7:0]      hdr_second = fpb_pkg::SYNC_SECOND_RST;
    fpb_pkg::phase_t rx_phase   = fpb_pkg::PH_HDR1;
    logic [7:0]      rx_len     = '0;
    logic [7:0]      rx_cmd     = '0;
    logic [7:0]      rx_check   = '0;
    logic [5:0]      rx_count   = '0;
    logic [7:0]      rx_payload[PAYLOAD_MAX];

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(12, 40);
    endfunction

    // Push the beats of a frame whose checksum matched
    task automatic emit_frame_beats();
        frame_beat_t beat;
        int          n;
        n = int'(rx_len) - 1;
        beat.frame_command = rx_cmd;
        if (n == 0) begin
            beat.data_count    = '0;
            beat.byte_position = '0;
            beat.data_value    = '0;
            beat.data_present  = 1'b0;
            beat.last_of_frame = 1'b1;
            frame_beats_due.push_back(beat);
        end else begin
            for (int k = 0; k < n && k < PAYLOAD_MAX; k++) begin
                beat.data_count    = 6'(n);
                beat.byte_position = 5'(k);
                beat.data_value    = rx_payload[5'(k)];
                beat.data_present  = 1'b1;
                beat.last_of_frame = (k + 1 == n);
                frame_beats_due.push_back(beat);
            end
        end
    endtask

    // Advance the parser mirror by one received byte
    task automatic parse_rx_byte(input logic [7:0] b);
        case (rx_phase)
            fpb_pkg::PH_HDR1: begin
                if (b == hdr_first)
                    rx_phase = fpb_pkg::PH_HDR2;
            end
            fpb_pkg::PH_HDR2: begin
                if (b == hdr_second)
                    rx_phase = fpb_pkg::PH_LEN;
                else if (b == hdr_first)
                    rx_phase = fpb_pkg::PH_HDR2;
                else
                    rx_phase = fpb_pkg::PH_HDR1;
            end
            fpb_pkg::PH_LEN: begin
                rx_len   = b;
                rx_check = b;
                if (b == 8'd0 || int'(b) > PAYLOAD_MAX + 1)
                    rx_phase = fpb_pkg::PH_HDR1;
                else
                    rx_phase = fpb_pkg::PH_CMD;
            end
            fpb_pkg::PH_CMD: begin
                rx_cmd   = b;
                rx_check = rx_check ^ b;
                if (rx_len > 8'd1) begin
                    rx_count = '0;
                    rx_phase = fpb_pkg::PH_DATA;
                end else begin
                    rx_phase = fpb_pkg::PH_CHK;
                end
            end
            fpb_pkg::PH_DATA: begin
                if (int'(rx_count) < PAYLOAD_MAX)
                    rx_payload[rx_count[4:0]] = b;
                rx_count = rx_count + 6'd1;
                rx_check = rx_check ^ b;
                if (int'(rx_count) >= int'(rx_len) - 1)
                    rx_phase = fpb_pkg::PH_CHK;
            end
            fpb_pkg::PH_CHK: begin
                if (b == rx_check)
                    emit_frame_beats();
                rx_phase = fpb_pkg::PH_HDR1;
            end
            default: rx_phase = fpb_pkg::PH_HDR1;
        endcase
    endtask

    // Drive one byte per request, with random gaps; predict on acceptance
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            in_gap   <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                parse_rx_byte(s_tdata);
                bytes_in <= bytes_in + 1;
            end
            if (!s_tvalid || s_tready) begin
                if (in_gap != 0) begin
                    s_tvalid <= 1'b0;
                    in_gap   <= in_gap - 1;
                end else if (rx_bytes_pending.size() != 0) begin
                    s_tdata  <= rx_bytes_pending.pop_front();
                    s_tvalid <= 1'b1;
                    in_gap   <= pick_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Hold off the receiver once, long enough to back up the input
    always @(posedge aclk) begin
        if (!aresetn) begin
            stall_left <= 0;
            stall_done <= 1'b0;
        end else if (!stall_done && bytes_in >= STALL_AT) begin
            stall_left <= STALL_TICKS;
            stall_done <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end
    end

    // Check each received beat against the oldest predicted one
    always @(posedge aclk) begin
        frame_beat_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            out_gap  <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (frame_beats_due.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("unexpected result: tdata=%h tuser=%b tlast=%b",
                                 m_tdata, m_tuser, m_tlast);
                end else begin
                    want = frame_beats_due.pop_front();
                    if (m_tdata[7:0]   !== want.frame_command ||
                        m_tdata[13:8]  !== want.data_count    ||
                        m_tdata[18:14] !== want.byte_position ||
                        m_tdata[26:19] !== want.data_value    ||
                        m_tdata[31:27] !== 5'd0               ||
                        m_tuser        !== want.data_present  ||
                        m_tlast        !== want.last_of_frame) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display({"mismatch: expected cmd=%h cnt=%0d pos=%0d val=%h ",
                                      "dp=%b last=%b, got cmd=%h cnt=%0d pos=%0d val=%h ",
                                      "fill=%h dp=%b last=%b"},
                                     want.frame_command, want.data_count,
                                     want.byte_position, want.data_value,
                                     want.data_present, want.last_of_frame,
                                     m_tdata[7:0], m_tdata[13:8], m_tdata[18:14],
                                     m_tdata[26:19], m_tdata[31:27], m_tuser, m_tlast);
                    end
                end
            end
            if (stall_left != 0) begin
                m_tready <= 1'b0;
            end else if (out_gap != 0) begin
                m_tready <= 1'b0;
                out_gap  <= out_gap - 1;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 2) == 0)
                    out_gap <= pick_gap();
            end
        end
    end

    task automatic queue_rx_byte(input logic [7:0] b);
        rx_bytes_pending.push_back(b);
        bytes_queued++;
    endtask

    // Queue a complete frame with random data; optionally spoil the checksum
    task automatic queue_frame(input int n_data, input bit spoil);
        logic [7:0] chk;
        logic [7:0] d;
        int         i;
        queue_rx_byte(hdr_first);
        queue_rx_byte(hdr_second);
        chk = 8'(n_data + 1);
        queue_rx_byte(chk);
        d = 8'($urandom);
        queue_rx_byte(d);
        chk = chk ^ d;
        for (i = 0; i < n_data; i++) begin
            d = 8'($urandom);
            queue_rx_byte(d);
            chk = chk ^ d;
        end
        if (spoil)
            chk = chk ^ 8'($urandom_range(1, 255));
        queue_rx_byte(chk);
    endtask

    function automatic int pick_data_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(0, 5);
        if (r < 96)
            return $urandom_range(6, 15);
        return $urandom_range(PAYLOAD_MAX - 1, PAYLOAD_MAX);
    endfunction

    // Mostly good frames, the rest broken frames and line noise
    task automatic queue_random_traffic(input int budget);
        int unsigned start;
        int          r;
        int          i;
        start = bytes_queued;
        queue_frame(PAYLOAD_MAX, 1'b0);
        while (bytes_queued - start < budget) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                queue_frame(pick_data_len(), 1'b0);
            end else if (r < 80) begin
                queue_frame(pick_data_len(), 1'b1);
            end else if (r < 86) begin
                queue_rx_byte(hdr_first);
                queue_rx_byte(hdr_second);
                if ($urandom_range(0, 1) == 0)
                    queue_rx_byte(8'd0);
                else
                    queue_rx_byte(8'($urandom_range(PAYLOAD_MAX + 2, 255)));
            end else if (r < 92) begin
                queue_rx_byte(hdr_first);
                queue_rx_byte(8'($urandom));
            end else begin
                for (i = $urandom_range(1, 4); i > 0; i--)
                    queue_rx_byte(8'($urandom));
            end
        end
    endtask

    // Wait until every byte is taken and every beat has arrived
    task automatic wait_drained();
        while (bytes_in != bytes_queued || frame_beats_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_TICKS) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [fpb_pkg::CFG_IDX_W-1:0] idx,
                             input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx == fpb_pkg::CFG_SYNC_FIRST)
            hdr_first = val;
        else if (idx == fpb_pkg::CFG_SYNC_SECOND)
            hdr_second = val;
        @(posedge aclk);
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Frame without data, command zero
        queue_rx_byte(fpb_pkg::SYNC_FIRST_RST);
        queue_rx_byte(fpb_pkg::SYNC_SECOND_RST);
        queue_rx_byte(8'h01);
        queue_rx_byte(8'h00);
        queue_rx_byte(8'h01);
        // Repeated first header byte, then one all-ones data byte
        queue_rx_byte(fpb_pkg::SYNC_FIRST_RST);
        queue_rx_byte(fpb_pkg::SYNC_FIRST_RST);
        queue_rx_byte(fpb_pkg::SYNC_SECOND_RST);
        queue_rx_byte(8'h02);
        queue_rx_byte(8'hFF);
        queue_rx_byte(8'hFF);
        queue_rx_byte(8'h02);
        // Zero length and one past the longest frame
        queue_rx_byte(fpb_pkg::SYNC_FIRST_RST);
        queue_rx_byte(fpb_pkg::SYNC_SECOND_RST);
        queue_rx_byte(8'h00);
        queue_rx_byte(fpb_pkg::SYNC_FIRST_RST);
        queue_rx_byte(fpb_pkg::SYNC_SECOND_RST);
        queue_rx_byte(8'(PAYLOAD_MAX + 2));
        // Bad checksum, then a frame that should still be found
        queue_rx_byte(fpb_pkg::SYNC_FIRST_RST);
        queue_rx_byte(fpb_pkg::SYNC_SECOND_RST);
        queue_rx_byte(8'h02);
        queue_rx_byte(8'h7E);
        queue_rx_byte(8'h00);
        queue_rx_byte(8'h7D);
        queue_frame(0, 1'b0);
        wait_drained();

        write_reg(fpb_pkg::CFG_SYNC_FIRST, 8'h00);
        write_reg(fpb_pkg::CFG_SYNC_SECOND, 8'hFF);
        queue_random_traffic(BUDGET);
        wait_drained();

        write_reg(fpb_pkg::CFG_SYNC_FIRST, 8'hFF);
        write_reg(fpb_pkg::CFG_SYNC_SECOND, 8'h00);
        queue_random_traffic(BUDGET);
        wait_drained();

        // Equal header bytes: the second match wins while hunting
        write_reg(fpb_pkg::CFG_SYNC_FIRST, 8'h3C);
        write_reg(fpb_pkg::CFG_SYNC_SECOND, 8'h3C);
        queue_rx_byte(8'h3C);
        queue_rx_byte(8'h3C);
        queue_rx_byte(8'h01);
        queue_rx_byte(8'h5A);
        queue_rx_byte(8'h5B);
        queue_rx_byte(8'h3C);
        queue_rx_byte(8'h3C);
        queue_rx_byte(8'h3C);
        quiet = 1'b1;
        queue_random_traffic(BUDGET);
        wait_drained();
        quiet = 1'b0;

        write_reg(fpb_pkg::CFG_SYNC_FIRST, 8'($urandom));
        write_reg(fpb_pkg::CFG_SYNC_SECOND, 8'($urandom));
        queue_random_traffic(BUDGET);
        wait_drained();

        write_reg(fpb_pkg::CFG_SYNC_FIRST, fpb_pkg::SYNC_FIRST_RST);
        write_reg(fpb_pkg::CFG_SYNC_SECOND, fpb_pkg::SYNC_SECOND_RST);
        queue_random_traffic(BUDGET);
        wait_drained();
        repeat (40) @(posedge aclk);

        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #5000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
